// ===== hdl/mpdt_pkg.sv =====
// Package for the mode persistence debounce tracker.
// Types, command and register codes, reset values shared by all hdl/ modules.
// No dependencies.
`default_nettype none

package mpdt_pkg;

    localparam int TIME_W      = 64;
    localparam int MODE_W      = 3;
    localparam int MS_W        = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int MODE_COUNT_DEF = 8;

    localparam int S_TDATA_W   = 72;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 8;

    localparam logic [MS_W-1:0] DWELL_RST    = 32'd500;
    localparam logic [MS_W-1:0] DEBOUNCE_RST = 32'd300;
    localparam logic [MS_W-1:0] SUPPRESS_RST = 32'd500;

    typedef enum logic [1:0] {
        CMD_OBSERVE = 2'd0,
        CMD_RESTORE = 2'd1,
        CMD_DRIFT   = 2'd2,
        CMD_ACCEPT  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED  = 2'd0,
        CFG_DWELL    = 2'd1,
        CFG_DEBOUNCE = 2'd2,
        CFG_SUPPRESS = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic            enabled;
        logic [MS_W-1:0] promotion_dwell_ms;
        logic [MS_W-1:0] adopt_debounce_ms;
        logic [MS_W-1:0] post_restore_suppress_ms;
    } cfg_t;

    typedef struct packed {
        cmd_t              command;
        logic [MODE_W-1:0] mode;
        logic              valid_req;
        logic [TIME_W-1:0] now;
        logic              restore_outstanding;
    } item_t;

    typedef struct packed {
        logic              action;
        logic              adopted;
        logic [MODE_W-1:0] desired_mode;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/mpdt_cfg.sv =====
// Configuration register file for the mode persistence debounce tracker.
// Depends on mpdt_pkg.
`default_nettype none

module mpdt_cfg
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mpdt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mpdt_pkg::MS_W-1:0]      cfg_data,
    output mpdt_pkg::cfg_t                      cfg
);
    import mpdt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ENABLED:  cfg_next.enabled                  = cfg_data[0];
                CFG_DWELL:    cfg_next.promotion_dwell_ms       = cfg_data;
                CFG_DEBOUNCE: cfg_next.adopt_debounce_ms        = cfg_data;
                CFG_SUPPRESS: cfg_next.post_restore_suppress_ms = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled                  <= 1'b1;
            cfg_reg.promotion_dwell_ms       <= DWELL_RST;
            cfg_reg.adopt_debounce_ms        <= DEBOUNCE_RST;
            cfg_reg.post_restore_suppress_ms <= SUPPRESS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mpdt_core.sv =====
// Tracker state and per-item event logic: settling test, restore request,
// debounced adoption. Depends on mpdt_pkg.
`default_nettype none

module mpdt_core
#(
    parameter int MODE_COUNT = mpdt_pkg::MODE_COUNT_DEF
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  wire mpdt_pkg::item_t item,
    input  wire mpdt_pkg::cfg_t  cfg,
    output mpdt_pkg::result_t    result
);
    import mpdt_pkg::*;

    logic [MODE_W-1:0] observed_reg,  observed_next;
    logic [MODE_W-1:0] carried_reg,   carried_next;
    logic [MODE_W-1:0] candidate_reg, candidate_next;
    logic [TIME_W-1:0] cand_since_reg, cand_since_next;
    logic [TIME_W-1:0] ctx_since_reg,  ctx_since_next;
    logic [TIME_W-1:0] suppress_reg,   suppress_next;

    logic [MODE_W-1:0] mode_c;
    logic [TIME_W-1:0] ctx_age;
    logic [TIME_W-1:0] cand_age;
    logic              settle;
    logic              live;
    logic              action;
    logic              adopted;

    assign mode_c   = (32'(item.mode) < MODE_COUNT) ? item.mode : '0;
    assign ctx_age  = item.now - ctx_since_reg;
    assign cand_age = item.now - cand_since_reg;
    assign settle   = (item.now < suppress_reg)
                   || (ctx_age < {{(TIME_W-MS_W){1'b0}}, cfg.promotion_dwell_ms})
                   || item.restore_outstanding;
    assign live     = cfg.enabled && !settle && (carried_reg != '0)
                   && (mode_c != carried_reg);

    always_comb
    begin
        observed_next   = observed_reg;
        carried_next    = carried_reg;
        candidate_next  = candidate_reg;
        cand_since_next = cand_since_reg;
        ctx_since_next  = ctx_since_reg;
        suppress_next   = suppress_reg;
        action          = 1'b0;
        adopted         = 1'b0;

        unique case (item.command)
            CMD_OBSERVE:
            begin
                if (!item.valid_req)
                begin
                    observed_next = '0;
                end
                else if (live && (observed_reg == '0))
                begin
                    observed_next = mode_c;
                    action        = 1'b1;
                end
                else
                begin
                    if (live && (mode_c != '0))
                    begin
                        if (candidate_reg != mode_c)
                        begin
                            candidate_next  = mode_c;
                            cand_since_next = item.now;
                        end
                        else if (cand_age >=
                                 {{(TIME_W-MS_W){1'b0}}, cfg.adopt_debounce_ms})
                        begin
                            carried_next   = mode_c;
                            candidate_next = '0;
                            adopted        = 1'b1;
                        end
                    end
                    else
                    begin
                        candidate_next = '0;
                    end
                    observed_next = mode_c;
                end
            end
            CMD_RESTORE:
            begin
                if (cfg.enabled)
                begin
                    if (carried_reg == '0)
                    begin
                        carried_next = observed_reg;
                    end
                    else
                    begin
                        action = 1'b1;
                    end
                end
            end
            CMD_DRIFT:
            begin
                observed_next  = '0;
                ctx_since_next = item.now;
            end
            CMD_ACCEPT:
            begin
                observed_next  = mode_c;
                ctx_since_next = item.now;
                suppress_next  = item.now
                               + {{(TIME_W-MS_W){1'b0}}, cfg.post_restore_suppress_ms};
            end
        endcase
    end

    assign result.action       = action;
    assign result.adopted      = adopted;
    assign result.desired_mode = carried_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            observed_reg   <= '0;
            carried_reg    <= '0;
            candidate_reg  <= '0;
            cand_since_reg <= '0;
            ctx_since_reg  <= '0;
            suppress_reg   <= '0;
        end
        else if (fire)
        begin
            observed_reg   <= observed_next;
            carried_reg    <= carried_next;
            candidate_reg  <= candidate_next;
            cand_since_reg <= cand_since_next;
            ctx_since_reg  <= ctx_since_next;
            suppress_reg   <= suppress_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mode_persistence_debounce_tracker.sv =====
// Top level of the mode persistence debounce tracker: input and result
// registers around mpdt_core, plus mpdt_cfg. Depends on mpdt_pkg.
//
//  channel   | signals                          | direction
//  ----------+----------------------------------+----------
//  s_axis    | s_tvalid s_tready s_tdata s_tuser| in
//  m_axis    | m_tvalid m_tready m_tdata        | out
//  cfg       | cfg_valid cfg_ready cfg_index    | in
//            | cfg_data                         |
//
// One item per cycle sustained while m_tready is high.
// Item goes input register -> event logic -> result register.
// m_tready low holds the result; the input register still takes an item
// while the result register is free or being drained.
// Reset clears all tracker state and loads register defaults; cfg_ready
// is always high.
`default_nettype none

module mode_persistence_debounce_tracker
#(
    parameter int MODE_COUNT = mpdt_pkg::MODE_COUNT_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [2:0] mode, [3] valid_req, [67:4] now, [68] restore_outstanding, rest zero
    input  wire logic [mpdt_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] command
    input  wire logic [mpdt_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [0] action, [1] adopted, [4:2] desired_mode, rest zero
    output logic [mpdt_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mpdt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mpdt_pkg::MS_W-1:0]      cfg_data
);
    import mpdt_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    logic    fire;
    cfg_t    cfg;
    result_t res;
    item_t   s_item;

    assign s_item.command             = cmd_t'(s_tuser);
    assign s_item.mode                = s_tdata[2:0];
    assign s_item.valid_req           = s_tdata[3];
    assign s_item.now                 = s_tdata[67:4];
    assign s_item.restore_outstanding = s_tdata[68];

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-MODE_W-2){1'b0}}, out_res_reg.desired_mode,
                       out_res_reg.adopted, out_res_reg.action};

    mpdt_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mpdt_core #(.MODE_COUNT(MODE_COUNT)) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= s_item;
        end
        if (fire)
        begin
            out_res_reg <= res;
        end
    end

endmodule

`default_nettype wire
